FILE: hw/rtl/fvam_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package fvam_pkg;

  // Divider width: the largest dividend is a FAT32 entry offset, cluster * 4.
  localparam int DIV_W      = 34;
  localparam int DIVISOR_W  = 16;
  localparam int STEP_CNT_W = $clog2(DIV_W);

  localparam logic [1:0] KIND_FAT12 = 2'd0;
  localparam logic [1:0] KIND_FAT16 = 2'd1;
  localparam logic [1:0] KIND_FAT32 = 2'd2;

  localparam logic [31:0] LIMIT_FAT12 = 32'd4085;
  localparam logic [31:0] LIMIT_FAT16 = 32'd65525;
  localparam logic [31:0] EOC_FAT32   = 32'h0FFF_FFF8;
  localparam logic [15:0] EOC_FAT16   = 16'hFFF8;
  localparam int          DIR_ENTRY_SHIFT = 5;  // 32 bytes per directory entry

  localparam logic [2:0] REG_BYTES_PER_SECTOR    = 3'd0;
  localparam logic [2:0] REG_SECTORS_PER_CLUSTER = 3'd1;
  localparam logic [2:0] REG_RESERVED_SECTORS    = 3'd2;
  localparam logic [2:0] REG_FAT_COPIES          = 3'd3;
  localparam logic [2:0] REG_ROOT_ENTRY_COUNT    = 3'd4;
  localparam logic [2:0] REG_FAT_SIZE_SECTORS    = 3'd5;
  localparam logic [2:0] REG_TOTAL_SECTORS       = 3'd6;

  typedef struct packed {
    logic [31:0] cluster_number;
    logic [31:0] fat_entry_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  fat_kind;
    logic [21:0] root_dir_sector_count;
    logic [31:0] data_start_sector;
    logic [31:0] cluster_total;
    logic        geometry_error;
    logic [31:0] cluster_first_sector;
    logic [31:0] entry_sector;
    logic [15:0] entry_byte_offset;
    logic        entry_location_valid;
    logic        chain_end;
  } out_item_t;

  // Volume figures that follow from configuration alone.
  typedef struct packed {
    logic [15:0] bps;
    logic [7:0]  spc;
    logic [15:0] reserved;
    logic [21:0] root_secs;
    logic [31:0] data_start;
    logic [31:0] clusters;
    logic        geo_err;
    logic [1:0]  kind;
  } geo_t;

  // Data that rides along with an entry offset through the divider.
  typedef struct packed {
    logic [31:0] first_sec;
    logic        chain_end;
  } div_side_t;

  typedef struct packed {
    logic [DIV_W-1:0]     num;
    logic [DIVISOR_W-1:0] rem;
  } div_state_t;

  typedef enum logic [2:0] {
    G_START,
    G_ROOT,
    G_META,
    G_CLUS,
    G_IDLE
  } geo_state_e;

  // One restoring division step: the dividend shifts out at the top while
  // quotient bits shift in at the bottom.
  function automatic div_state_t div_step(input div_state_t s,
                                          input logic [DIVISOR_W-1:0] d);
    logic [DIVISOR_W:0] t;
    div_state_t         r;
    t = {s.rem, s.num[DIV_W-1]};
    if (t >= {1'b0, d}) begin
      r.rem = DIVISOR_W'(t - {1'b0, d});
      r.num = {s.num[DIV_W-2:0], 1'b1};
    end else begin
      r.rem = t[DIVISOR_W-1:0];
      r.num = {s.num[DIV_W-2:0], 1'b0};
    end
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/fvam_geom.sv
`timescale 1ns / 1ps
`default_nettype none
module fvam_geom (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_write,
  input  wire logic [2:0]          cfg_index,
  input  wire logic [31:0]         cfg_data,
  output fvam_pkg::geo_t           geo,
  output logic                     busy
);
  import fvam_pkg::*;

  logic [15:0] bytes_per_sector;
  logic [7:0]  sectors_per_cluster;
  logic [15:0] reserved_sectors;
  logic [7:0]  fat_copies;
  logic [15:0] root_entry_count;
  logic [31:0] fat_size_sectors;
  logic [31:0] total_sectors;

  geo_state_e state, state_next;
  logic [STEP_CNT_W-1:0] cnt, cnt_next;
  div_state_t dv, dv_next;
  logic [21:0] root_secs, root_secs_next;
  logic [31:0] data_start, data_start_next;
  logic [31:0] clusters, clusters_next;
  logic        geo_err, geo_err_next;

  logic [15:0] bps_eff;
  logic [7:0]  spc_eff;
  logic [40:0] meta;
  div_state_t  stepped;
  logic [15:0] divisor;

  assign bps_eff = (bytes_per_sector == '0) ? 16'd1 : bytes_per_sector;
  assign spc_eff = (sectors_per_cluster == '0) ? 8'd1 : sectors_per_cluster;
  assign meta = 41'(reserved_sectors) + 41'(fat_copies) * 41'(fat_size_sectors)
              + 41'(root_secs);
  assign divisor = (state == G_CLUS) ? {8'd0, spc_eff} : bps_eff;
  assign stepped = div_step(dv, divisor);

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_per_sector    <= 16'd512;
      sectors_per_cluster <= 8'd1;
      reserved_sectors    <= 16'd1;
      fat_copies          <= 8'd2;
      root_entry_count    <= 16'd512;
      fat_size_sectors    <= '0;
      total_sectors       <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_BYTES_PER_SECTOR:    bytes_per_sector    <= cfg_data[15:0];
        REG_SECTORS_PER_CLUSTER: sectors_per_cluster <= cfg_data[7:0];
        REG_RESERVED_SECTORS:    reserved_sectors    <= cfg_data[15:0];
        REG_FAT_COPIES:          fat_copies          <= cfg_data[7:0];
        REG_ROOT_ENTRY_COUNT:    root_entry_count    <= cfg_data[15:0];
        REG_FAT_SIZE_SECTORS:    fat_size_sectors    <= cfg_data;
        REG_TOTAL_SECTORS:       total_sectors       <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= G_START;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
    dv         <= dv_next;
    root_secs  <= root_secs_next;
    data_start <= data_start_next;
    clusters   <= clusters_next;
    geo_err    <= geo_err_next;
  end

  always_comb begin
    state_next      = state;
    cnt_next        = cnt;
    dv_next         = dv;
    root_secs_next  = root_secs;
    data_start_next = data_start;
    clusters_next   = clusters;
    geo_err_next    = geo_err;
    case (state)
      G_START: begin
        dv_next.num = DIV_W'({root_entry_count, {DIR_ENTRY_SHIFT{1'b0}}})
                    + DIV_W'(bps_eff) - DIV_W'(1);
        dv_next.rem = '0;
        cnt_next    = '0;
        state_next  = G_ROOT;
      end
      G_ROOT: begin
        dv_next  = stepped;
        cnt_next = cnt + 1'b1;
        if (cnt == STEP_CNT_W'(DIV_W - 1)) begin
          root_secs_next = stepped.num[21:0];
          state_next     = G_META;
        end
      end
      G_META: begin
        data_start_next = meta[31:0];
        geo_err_next    = {9'd0, total_sectors} < meta;
        dv_next.num     = (({9'd0, total_sectors} < meta)) ? '0
                        : DIV_W'(total_sectors - meta[31:0]);
        dv_next.rem     = '0;
        cnt_next        = '0;
        state_next      = G_CLUS;
      end
      G_CLUS: begin
        dv_next  = stepped;
        cnt_next = cnt + 1'b1;
        if (cnt == STEP_CNT_W'(DIV_W - 1)) begin
          clusters_next = stepped.num[31:0];
          state_next    = G_IDLE;
        end
      end
      G_IDLE: ;
      default: state_next = G_START;
    endcase
    // Any register write invalidates the figures; recompute from the top.
    if (cfg_write) begin
      state_next = G_START;
    end
  end

  assign busy           = (state != G_IDLE);
  assign geo.bps        = bps_eff;
  assign geo.spc        = spc_eff;
  assign geo.reserved   = reserved_sectors;
  assign geo.root_secs  = root_secs;
  assign geo.data_start = data_start;
  assign geo.clusters   = clusters;
  assign geo.geo_err    = geo_err;
  assign geo.kind       = (clusters < LIMIT_FAT12) ? KIND_FAT12
                        : (clusters < LIMIT_FAT16) ? KIND_FAT16 : KIND_FAT32;

`ifndef SYNTH
  a_write_restarts: assert property (@(posedge clk) disable iff (rst)
    cfg_write |=> state == G_START)
    else $error("register write did not restart the geometry sequence");
  a_cnt_idle: assert property (@(posedge clk) disable iff (rst)
    (state == G_ROOT || state == G_CLUS) |-> cnt <= STEP_CNT_W'(DIV_W - 1))
    else $error("division step count ran past its end");
  a_err_empty: assert property (@(posedge clk) disable iff (rst)
    (state == G_IDLE && geo_err) |-> clusters == '0)
    else $error("undersized volume reports clusters");
`endif

endmodule
`default_nettype wire

FILE: hw/rtl/fvam_div.sv
`timescale 1ns / 1ps
`default_nettype none
module fvam_div (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  input  wire logic [fvam_pkg::DIV_W-1:0]          in_num,
  input  wire fvam_pkg::div_side_t                 in_side,
  input  wire logic [fvam_pkg::DIVISOR_W-1:0]      divisor,
  output logic                                     out_valid,
  output logic [fvam_pkg::DIV_W-1:0]               out_quot,
  output logic [fvam_pkg::DIVISOR_W-1:0]           out_rem,
  output fvam_pkg::div_side_t                      out_side
);
  import fvam_pkg::*;

  // One quotient bit per stage.
  logic       vld  [DIV_W];
  div_state_t st   [DIV_W];
  div_side_t  side [DIV_W];
  div_state_t first_in;

  assign first_in.num = in_num;
  assign first_in.rem = '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= in_valid;
    end
    st[0]   <= div_step(first_in, divisor);
    side[0] <= in_side;
  end

  for (genvar k = 1; k < DIV_W; k++) begin : g_stage
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else begin
        vld[k] <= vld[k-1];
      end
      st[k]   <= div_step(st[k-1], divisor);
      side[k] <= side[k-1];
    end
  end

  assign out_valid = vld[DIV_W-1];
  assign out_quot  = st[DIV_W-1].num;
  assign out_rem   = st[DIV_W-1].rem;
  assign out_side  = side[DIV_W-1];

`ifndef SYNTH
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_rem < divisor)
    else $error("division remainder not below divisor");
  a_flow: assert property (@(posedge clk) disable iff (rst)
    vld[0] |-> ##(DIV_W - 1) out_valid)
    else $error("divider lost an item");
  a_reset: assert property (@(posedge clk)
    rst |=> !vld[0])
    else $error("divider stage valid after reset");
`endif

endmodule
`default_nettype wire

FILE: hw/rtl/fat_volume_address_mapper.sv
`timescale 1ns / 1ps
`default_nettype none
// FAT volume address mapper.
//
// Configuration: write cfg_data to register cfg_index while cfg_write is
// high. Each write starts a recompute of the volume figures (root directory
// sectors, data start, cluster count, FAT type); busy stays high while two
// 34-step iterative divisions and a multiply-add run.
// Reset loads the default geometry and starts the same recompute.
//
// Lookups: a transfer happens at a clock edge where start is high and busy
// is low. A new cluster may follow in every cycle while busy stays low. Each
// transfer yields one result on the result port, flagged by done for exactly
// one cycle. Each item passes the input, multiply and add registers, then the
// entry offset divider, which resolves one quotient bit per pipeline stage
// over 34 stages, and last the output register.
// The receiver cannot stall: every result is taken in the cycle done is
// high, so the pipeline never holds and never drops an item.
module fat_volume_address_mapper (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  output logic                     busy,
  input  wire fvam_pkg::in_item_t  item,
  output logic                     done,
  output fvam_pkg::out_item_t      result,
  input  wire logic                cfg_write,
  input  wire logic [2:0]          cfg_index,
  input  wire logic [31:0]         cfg_data
);
  import fvam_pkg::*;

  geo_t geo;

  fvam_geom u_geom (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .geo       (geo),
    .busy      (busy)
  );

  // Stage 0: capture the transfer.
  logic     v0;
  in_item_t s0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else begin
      v0 <= start && !busy;
    end
    s0 <= item;
  end

  // Stage 1: cluster minus two times cluster size, FAT entry offset, end-of-chain test.
  logic             v1;
  logic [31:0]      prod1;
  logic [DIV_W-1:0] off1;
  logic             eoc1;
  logic             root1;
  logic [31:0]      c_minus2;

  assign c_minus2 = s0.cluster_number - 32'd2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= v0;
    end
    prod1 <= 32'(c_minus2 * geo.spc);
    off1  <= (geo.kind == KIND_FAT32) ? {s0.cluster_number, 2'b00}
                                      : {1'b0, s0.cluster_number, 1'b0};
    case (geo.kind)
      KIND_FAT32: eoc1 <= s0.fat_entry_value >= EOC_FAT32;
      KIND_FAT16: eoc1 <= s0.fat_entry_value[15:0] >= EOC_FAT16;
      default:    eoc1 <= 1'b0;
    endcase
    // On FAT16 cluster zero stands for the fixed root directory.
    root1 <= (geo.kind == KIND_FAT16) && (s0.cluster_number == '0);
  end

  // Stage 2: the cluster's first sector.
  logic             v2;
  logic [DIV_W-1:0] off2;
  div_side_t        side2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    off2            <= off1;
    side2.chain_end <= eoc1;
    side2.first_sec <= root1 ? geo.data_start - {10'd0, geo.root_secs}
                             : geo.data_start + prod1;
  end

  // Entry offset split into sector and byte within sector.
  logic                 dv;
  logic [DIV_W-1:0]     quot;
  logic [DIVISOR_W-1:0] rem;
  div_side_t            side_d;

  fvam_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v2),
    .in_num    (off2),
    .in_side   (side2),
    .divisor   (geo.bps),
    .out_valid (dv),
    .out_quot  (quot),
    .out_rem   (rem),
    .out_side  (side_d)
  );

  // Output register. The user must keep the volume figures fixed while items are in
  // flight (the block does not enforce it); they are taken straight from the geometry unit.
  logic fat12;
  assign fat12 = (geo.kind == KIND_FAT12);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= dv;
    end
    result.fat_kind              <= geo.kind;
    result.root_dir_sector_count <= geo.root_secs;
    result.data_start_sector     <= geo.data_start;
    result.cluster_total         <= geo.clusters;
    result.geometry_error        <= geo.geo_err;
    result.cluster_first_sector  <= side_d.first_sec;
    result.entry_sector          <= fat12 ? '0 : {16'd0, geo.reserved} + quot[31:0];
    result.entry_byte_offset     <= fat12 ? '0 : rem;
    result.entry_location_valid  <= !fat12;
    result.chain_end             <= fat12 ? 1'b0 : side_d.chain_end;
  end

`ifndef SYNTH
  a_valid_kind: assert property (@(posedge clk) disable iff (rst)
    done |-> result.entry_location_valid == (result.fat_kind != KIND_FAT12))
    else $error("entry valid flag disagrees with FAT type");
  a_fat12_zero: assert property (@(posedge clk) disable iff (rst)
    (done && result.fat_kind == KIND_FAT12) |->
      (result.entry_sector == '0 && result.chain_end == 1'b0))
    else $error("FAT12 result carries an entry location");
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##38 done)
    else $error("result did not appear at the fixed latency");
  a_reset: assert property (@(posedge clk)
    rst |=> !done)
    else $error("done high right after reset");
`endif

endmodule
`default_nettype wire

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// Testbench for the FAT volume address mapper. Lookups go in through the
// start/busy command port, results come back one per transfer, marked by done.
// A scoreboard class predicts each result from its own copy of the geometry
// registers and checks the results in order.

class lookup_scoreboard;
  logic [15:0] bytes_per_sector = 16'd512;
  logic [7:0]  sectors_per_cluster = 8'd1;
  logic [15:0] reserved_sectors = 16'd1;
  logic [7:0]  fat_copies = 8'd2;
  logic [15:0] root_entry_count = 16'd512;
  logic [31:0] fat_size_sectors = 32'd0;
  logic [31:0] total_sectors = 32'd0;
  fvam_pkg::out_item_t pending_results[$];
  int errors = 0;

  function void write_register(logic [2:0] idx, logic [31:0] value);
    case (idx)
      fvam_pkg::REG_BYTES_PER_SECTOR: bytes_per_sector = value[15:0];
      fvam_pkg::REG_SECTORS_PER_CLUSTER: sectors_per_cluster = value[7:0];
      fvam_pkg::REG_RESERVED_SECTORS: reserved_sectors = value[15:0];
      fvam_pkg::REG_FAT_COPIES: fat_copies = value[7:0];
      fvam_pkg::REG_ROOT_ENTRY_COUNT: root_entry_count = value[15:0];
      fvam_pkg::REG_FAT_SIZE_SECTORS: fat_size_sectors = value;
      fvam_pkg::REG_TOTAL_SECTORS: total_sectors = value;
      default: ;
    endcase
  endfunction

  function fvam_pkg::out_item_t map_cluster(fvam_pkg::in_item_t it);
    fvam_pkg::out_item_t r;
    logic [63:0] bps, spc, root, meta, data_secs, clusters, fat_off;
    bps = (bytes_per_sector == 0) ? 64'd1 : 64'(bytes_per_sector);
    spc = (sectors_per_cluster == 0) ? 64'd1 : 64'(sectors_per_cluster);
    root = (64'(root_entry_count) * 32 + bps - 1) / bps;
    meta = 64'(reserved_sectors) + 64'(fat_copies) * 64'(fat_size_sectors) + root;
    r = '0;
    r.root_dir_sector_count = root[21:0];
    r.data_start_sector = meta[31:0];
    r.geometry_error = 64'(total_sectors) < meta;
    data_secs = r.geometry_error ? 64'd0 : 64'(total_sectors) - meta;
    clusters = data_secs / spc;
    r.cluster_total = clusters[31:0];
    if (clusters < 64'(fvam_pkg::LIMIT_FAT12)) r.fat_kind = fvam_pkg::KIND_FAT12;
    else if (clusters < 64'(fvam_pkg::LIMIT_FAT16)) r.fat_kind = fvam_pkg::KIND_FAT16;
    else r.fat_kind = fvam_pkg::KIND_FAT32;
    // On FAT16 cluster zero stands for the fixed root directory.
    if (r.fat_kind == fvam_pkg::KIND_FAT16 && it.cluster_number == 0)
      r.cluster_first_sector = meta[31:0] - root[31:0];
    else
      r.cluster_first_sector = meta[31:0] + 32'(64'(it.cluster_number - 32'd2) * spc);
    if (r.fat_kind != fvam_pkg::KIND_FAT12) begin
      fat_off = 64'(it.cluster_number) *
                ((r.fat_kind == fvam_pkg::KIND_FAT32) ? 64'd4 : 64'd2);
      r.entry_sector = 32'(64'(reserved_sectors) + fat_off / bps);
      r.entry_byte_offset = 16'(fat_off % bps);
      r.entry_location_valid = 1'b1;
      if (r.fat_kind == fvam_pkg::KIND_FAT32)
        r.chain_end = it.fat_entry_value >= fvam_pkg::EOC_FAT32;
      else
        r.chain_end = it.fat_entry_value[15:0] >= fvam_pkg::EOC_FAT16;
    end
    return r;
  endfunction

  function void note_lookup(fvam_pkg::in_item_t it);
    pending_results.push_back(map_cluster(it));
  endfunction

  function void check_result(fvam_pkg::out_item_t got);
    fvam_pkg::out_item_t exp;
    if (pending_results.size() == 0) begin
      $display("%0t: unexpected result %h", $time, got);
      errors++;
      return;
    end
    exp = pending_results.pop_front();
    if (got.fat_kind !== exp.fat_kind)
      $display("%0t: fat_kind exp %0d got %0d", $time, exp.fat_kind, got.fat_kind);
    if (got.root_dir_sector_count !== exp.root_dir_sector_count)
      $display("%0t: root_dir_sector_count exp %0d got %0d", $time,
               exp.root_dir_sector_count, got.root_dir_sector_count);
    if (got.data_start_sector !== exp.data_start_sector)
      $display("%0t: data_start_sector exp %h got %h", $time,
               exp.data_start_sector, got.data_start_sector);
    if (got.cluster_total !== exp.cluster_total)
      $display("%0t: cluster_total exp %h got %h", $time,
               exp.cluster_total, got.cluster_total);
    if (got.geometry_error !== exp.geometry_error)
      $display("%0t: geometry_error exp %b got %b", $time,
               exp.geometry_error, got.geometry_error);
    if (got.cluster_first_sector !== exp.cluster_first_sector)
      $display("%0t: cluster_first_sector exp %h got %h", $time,
               exp.cluster_first_sector, got.cluster_first_sector);
    if (got.entry_sector !== exp.entry_sector)
      $display("%0t: entry_sector exp %h got %h", $time,
               exp.entry_sector, got.entry_sector);
    if (got.entry_byte_offset !== exp.entry_byte_offset)
      $display("%0t: entry_byte_offset exp %h got %h", $time,
               exp.entry_byte_offset, got.entry_byte_offset);
    if (got.entry_location_valid !== exp.entry_location_valid)
      $display("%0t: entry_location_valid exp %b got %b", $time,
               exp.entry_location_valid, got.entry_location_valid);
    if (got.chain_end !== exp.chain_end)
      $display("%0t: chain_end exp %b got %b", $time, exp.chain_end, got.chain_end);
    if (got !== exp) errors++;
  endfunction
endclass

module tb_top;
  import fvam_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  in_item_t item = '0;
  logic done;
  out_item_t result;
  logic cfg_write = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  lookup_scoreboard lookups = new();
  int sender_idle_pct = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  fat_volume_address_mapper i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .done(done), .result(result), .cfg_write(cfg_write),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Results cannot be held off, so each done cycle is checked at its edge.
  always @(posedge clk) begin
    if (!rst && done) lookups.check_result(result);
  end

  // Offers one lookup and holds it until the transfer happens. Random gaps
  // before the offer follow the sender idle rate of the current phase.
  // Start stays high after the transfer so the next lookup can follow at
  // once; drain_pipeline drops it.
  task automatic send_lookup(input logic [31:0] cluster, input logic [31:0] entry);
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    item <= '{cluster_number: cluster, fat_entry_value: entry};
    do @(posedge clk); while (busy);
    lookups.note_lookup('{cluster_number: cluster, fat_entry_value: entry});
    @(negedge clk);
  endtask

  // Waits until the pipeline has drained and the recompute has finished.
  task automatic drain_pipeline();
    start <= 1'b0;
    while (lookups.pending_results.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    while (busy) @(negedge clk);
  endtask

  // The block is only reconfigured while no lookup is in flight.
  task automatic write_geometry(input logic [2:0] idx, input logic [31:0] value);
    drain_pipeline();
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    lookups.write_register(idx, value);
    @(negedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
    while (busy) @(negedge clk);
  endtask

  // Picks a cluster number with extreme values mixed in.
  function automatic logic [31:0] pick_cluster();
    case ($urandom_range(5))
      0: return 32'($urandom_range(3));
      1: return 32'hFFFF_FFFF - 32'($urandom_range(3));
      2: return 32'($urandom_range(70000));
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_entry();
    case ($urandom_range(3))
      0: return EOC_FAT32 + 32'($urandom_range(7)) - 32'd1;
      1: return {$urandom_range(65535) > 0 ? 16'($urandom) : 16'h0,
                 EOC_FAT16 + 16'($urandom_range(7)) - 16'd1};
      default: return $urandom;
    endcase
  endfunction

  // Programs one volume geometry; the shape picks a FAT type or an edge.
  task automatic program_volume(input int shape);
    logic [31:0] tot;
    write_geometry(REG_BYTES_PER_SECTOR, (shape % 4 == 0) ? 32'($urandom_range(1, 65535))
                   : ((shape % 4 == 1) ? 32'd0 : 32'd512 << $urandom_range(2)));
    write_geometry(REG_SECTORS_PER_CLUSTER, (shape % 5 == 0) ? 32'd0
                   : 32'($urandom_range(1, (shape % 3 == 0) ? 255 : 8)));
    write_geometry(REG_RESERVED_SECTORS, $urandom_range(1) ? 32'($urandom_range(65535))
                   : 32'($urandom_range(40)));
    write_geometry(REG_FAT_COPIES, 32'($urandom_range(3) == 0 ? $urandom_range(255)
                                                              : $urandom_range(2)));
    write_geometry(REG_ROOT_ENTRY_COUNT, $urandom_range(1) ? 32'($urandom_range(65535))
                   : 32'd0);
    write_geometry(REG_FAT_SIZE_SECTORS, $urandom_range(3) == 0 ? $urandom
                   : 32'($urandom_range(3000)));
    case (shape % 4)
      0: tot = 32'($urandom_range(100000));
      1: tot = 32'($urandom_range(3000000));
      2: tot = $urandom;
      default: tot = 32'hFFFF_FFFF;
    endcase
    write_geometry(REG_TOTAL_SECTORS, tot);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    while (busy) @(negedge clk);

    // Directed part: reset geometry (too small volume), then fixed FAT12,
    // FAT16 and FAT32 volumes with cluster and end-of-chain extremes.
    send_lookup(32'd0, 32'd0);
    send_lookup(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    write_geometry(REG_TOTAL_SECTORS, 32'd2000);
    send_lookup(32'd2, 32'h0000_0FF8);
    send_lookup(32'd1, 32'hFFFF_FFFF);
    write_geometry(REG_TOTAL_SECTORS, 32'd40000);
    send_lookup(32'd0, 32'h0000_FFF8);
    send_lookup(32'd0, 32'h0000_FFF7);
    send_lookup(32'hFFFF_FFFF, 32'hFFFF_FFF7);
    send_lookup(32'd2, 32'h1234_FFFF);
    write_geometry(REG_ROOT_ENTRY_COUNT, 32'd0);
    write_geometry(REG_TOTAL_SECTORS, 32'hFFFF_FFFF);
    send_lookup(32'd0, EOC_FAT32);
    send_lookup(32'd1, EOC_FAT32 - 32'd1);
    send_lookup(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_lookup(32'h8000_0000, 32'h0);
    write_geometry(REG_BYTES_PER_SECTOR, 32'd0);
    write_geometry(REG_SECTORS_PER_CLUSTER, 32'd0);
    send_lookup(32'hFFFF_FFFF, 32'h0FFF_FFF8);
    write_geometry(REG_BYTES_PER_SECTOR, 32'd65535);
    write_geometry(REG_SECTORS_PER_CLUSTER, 32'd255);
    write_geometry(REG_RESERVED_SECTORS, 32'd65535);
    write_geometry(REG_FAT_COPIES, 32'd255);
    write_geometry(REG_ROOT_ENTRY_COUNT, 32'd65535);
    write_geometry(REG_FAT_SIZE_SECTORS, 32'hFFFF_FFFF);
    send_lookup(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_lookup(32'd0, 32'd0);

    // Random part in three idle phases; each phase runs several volumes.
    for (int phase = 0; phase < 3; phase++) begin
      sender_idle_pct = (phase == 0) ? 26 : ((phase == 1) ? 78 : 0);
      for (int vol = 0; vol < 12; vol++) begin
        program_volume($urandom_range(59));
        for (int n = 0; n < 50; n++) send_lookup(pick_cluster(), pick_entry());
        // Hold the sender off until every result of this volume is back.
        if (vol == 5) drain_pipeline();
      end
    end

    drain_pipeline();
    if (lookups.errors == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

  initial begin
    #20ms;
    $display("FAILURE");
    $finish;
  end
endmodule
